### sv/tod_pkg.sv
// shared types and constants for the terminal output discipline
package tod_pkg;

    // configuration register indexes
    localparam int unsigned CfgIdxW = 4;
    localparam int unsigned CfgDataW = 2;
    localparam logic [CfgIdxW-1:0] REG_RAW_MODE       = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_EXPAND_TABS    = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_UPPER_CASE     = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_MAP_CRLF       = 4'd3;
    localparam logic [CfgIdxW-1:0] REG_NEWLINE_DELAY  = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_TAB_DELAY      = 4'd5;
    localparam logic [CfgIdxW-1:0] REG_RETURN_DELAY   = 4'd6;
    localparam logic [CfgIdxW-1:0] REG_VERTICAL_DELAY = 4'd7;

    // character codes
    localparam logic [6:0] CH_BS    = 7'h08;
    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_VT    = 7'h0B;
    localparam logic [6:0] CH_FF    = 7'h0C;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_EOT   = 7'h04;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_TILDE = 7'h7E;
    localparam logic [6:0] CH_BSL   = 7'h5C;

    // delay kind codes
    localparam logic [1:0] DLY_KIND_ONE = 2'd1;
    localparam logic [1:0] DLY_KIND_TWO = 2'd2;

    typedef struct packed {
        logic       raw_mode;
        logic       expand_tabs;
        logic       upper_case_only;
        logic       map_newline_to_crlf;
        logic [1:0] newline_delay_kind;
        logic [1:0] tab_delay_kind;
        logic [1:0] return_delay_kind;
        logic       vertical_delay;
    } t_cfg;

    // which byte the datapath puts into the output register
    typedef enum logic [2:0] {
        SEL_BSL,
        SEL_CR,
        SEL_CHAR,
        SEL_SPACE,
        SEL_DLY
    } t_sel;

    typedef struct packed {
        logic load;
        logic emit;
        t_sel sel;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic tab;
        logic esc;
        logic cr;
        logic dly_nz;
        logic tab_stop;
        logic slot_free;
    } t_sts;

endpackage

### sv/tod_in_if.sv
// input channel: one character per transaction
interface tod_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

### sv/tod_out_if.sv
// output channel: one queue byte per transaction
interface tod_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

### sv/tod_dp.sv
// datapath: character mapping, print column, delay computation and output register
module tod_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tod_pkg::t_cfg     i_cfg,
    input  tod_pkg::t_cmd     i_cmd,
    output tod_pkg::t_sts     o_sts,
    input  logic [6:0]        i_in_char,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last,
    input  logic              i_out_ready
);

    typedef struct packed {
        logic [7:0] col;
        logic [6:0] dly;
    } t_step;

    function automatic t_step put_char(input logic [6:0] code, input logic [7:0] col,
                                       input tod_pkg::t_cfg cfg);
        t_step      s;
        logic [4:0] nl;
        s.col = col;
        s.dly = 7'd0;
        nl = {1'b0, col[7:4]} + 5'd3;
        if (code == tod_pkg::CH_BS) begin
            if (col != 8'd0) s.col = col - 8'd1;
        end else if (code == tod_pkg::CH_TAB) begin
            if (cfg.tab_delay_kind == tod_pkg::DLY_KIND_ONE && col[2:0] <= 3'd4)
                s.dly = 7'd9 - {4'd0, col[2:0]};
            s.col = (col | 8'h07) + 8'd1;
        end else if (code == tod_pkg::CH_LF) begin
            if (cfg.newline_delay_kind == tod_pkg::DLY_KIND_ONE) begin
                if (col != 8'd0) s.dly = (nl < 5'd6) ? 7'd6 : {2'd0, nl};
            end else if (cfg.newline_delay_kind == tod_pkg::DLY_KIND_TWO) begin
                s.dly = 7'd6;
            end
            s.col = 8'd0;
        end else if (code == tod_pkg::CH_VT || code == tod_pkg::CH_FF) begin
            if (cfg.vertical_delay) s.dly = 7'h7F;
        end else if (code == tod_pkg::CH_CR) begin
            if (cfg.return_delay_kind == tod_pkg::DLY_KIND_ONE) s.dly = 7'd5;
            else if (cfg.return_delay_kind == tod_pkg::DLY_KIND_TWO) s.dly = 7'd10;
            s.col = 8'd0;
        end else if (code >= tod_pkg::CH_SPACE && code <= tod_pkg::CH_TILDE) begin
            s.col = col + 8'd1;
        end
        return s;
    endfunction

    logic [6:0] r_char;
    logic       r_drop, r_tab, r_esc, r_cr;
    logic [7:0] r_col;
    logic [6:0] r_delay;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [6:0] w_sub;
    logic [6:0] w_mapped;
    logic [6:0] w_code;
    t_step      w_step;

    // upper-case folding and backslash escapes
    always_comb begin
        w_sub = 7'd0;
        if (i_cfg.upper_case_only) begin
            unique case (i_in_char)
                7'h7B:   w_sub = 7'h28;
                7'h7D:   w_sub = 7'h29;
                7'h7C:   w_sub = 7'h21;
                7'h7E:   w_sub = 7'h5E;
                7'h60:   w_sub = 7'h27;
                default: w_sub = 7'd0;
            endcase
        end
        w_mapped = (w_sub != 7'd0) ? w_sub : i_in_char;
        if (i_cfg.upper_case_only && w_mapped >= 7'h61 && w_mapped <= 7'h7A)
            w_mapped = w_mapped - 7'd32;
    end

    always_comb begin
        unique case (i_cmd.sel)
            tod_pkg::SEL_BSL:   w_code = tod_pkg::CH_BSL;
            tod_pkg::SEL_CR:    w_code = tod_pkg::CH_CR;
            tod_pkg::SEL_SPACE: w_code = tod_pkg::CH_SPACE;
            default:            w_code = r_char;
        endcase
        w_step = put_char(w_code, r_col, i_cfg);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= w_mapped;
            r_esc  <= (w_sub != 7'd0);
            r_drop <= (i_in_char == tod_pkg::CH_EOT) && !i_cfg.raw_mode;
            r_tab  <= (i_in_char == tod_pkg::CH_TAB) && i_cfg.expand_tabs;
            r_cr   <= (w_mapped == tod_pkg::CH_LF) && i_cfg.map_newline_to_crlf;
        end
        if (i_cmd.emit) begin
            r_out_last <= i_cmd.last;
            if (i_cmd.sel == tod_pkg::SEL_DLY) begin
                r_out_byte <= {1'b1, r_delay};
            end else begin
                r_out_byte <= {1'b0, w_code};
                r_delay    <= w_step.dly;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit && i_cmd.sel != tod_pkg::SEL_DLY) r_col <= w_step.col;
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_sts.drop      = r_drop;
    assign o_sts.tab       = r_tab;
    assign o_sts.esc       = r_esc;
    assign o_sts.cr        = r_cr;
    assign o_sts.dly_nz    = (w_step.dly != 7'd0);
    assign o_sts.tab_stop  = (w_step.col[2:0] == 3'd0);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

### sv/tod_ctrl.sv
// controller: sequences the bytes of one character
module tod_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tod_pkg::t_sts i_sts,
    output tod_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISP     = 8'b0000_0010,
        S_ESC      = 8'b0000_0100,
        S_CR       = 8'b0000_1000,
        S_CR_DLY   = 8'b0001_0000,
        S_CHAR     = 8'b0010_0000,
        S_CHAR_DLY = 8'b0100_0000,
        S_TAB      = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.sel  = tod_pkg::SEL_CHAR;
        o_cmd.last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_sts.drop) n_state = S_IDLE;
                else if (i_sts.tab)      n_state = S_TAB;
                else if (i_sts.esc)      n_state = S_ESC;
                else if (i_sts.cr)       n_state = S_CR;
                else                     n_state = S_CHAR;
            end
            S_ESC: begin
                o_cmd.sel = tod_pkg::SEL_BSL;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.cr ? S_CR : S_CHAR;
                end
            end
            S_CR: begin
                o_cmd.sel = tod_pkg::SEL_CR;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.dly_nz ? S_CR_DLY : S_CHAR;
                end
            end
            S_CR_DLY: begin
                o_cmd.sel = tod_pkg::SEL_DLY;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_CHAR;
                end
            end
            S_CHAR: begin
                o_cmd.sel  = tod_pkg::SEL_CHAR;
                o_cmd.last = !i_sts.dly_nz;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.dly_nz ? S_CHAR_DLY : S_IDLE;
                end
            end
            S_CHAR_DLY: begin
                o_cmd.sel  = tod_pkg::SEL_DLY;
                o_cmd.last = 1'b1;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TAB: begin
                // spaces until the column reaches a multiple of eight
                o_cmd.sel  = tod_pkg::SEL_SPACE;
                o_cmd.last = i_sts.tab_stop;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.tab_stop ? S_IDLE : S_TAB;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### sv/terminal_output_discipline.sv
// Terminal output discipline: takes one 7-bit character per transaction and
// produces the output-queue bytes for it (characters below 128, delay bytes of
// 128 and above), tracking the print column. One character at a time is in
// work: it is accepted in the idle state, decoded, then emits one output byte
// per cycle while the output register has room (1 to 8 bytes per character; a
// dropped EOT yields none). The output register lets the next character be
// accepted while the last byte still waits.
module terminal_output_discipline (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tod_in_if.sink                          i_in,
    tod_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [tod_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [tod_pkg::CfgDataW-1:0]    i_cfg_data
);

    tod_pkg::t_cfg r_cfg;
    tod_pkg::t_cmd w_cmd;
    tod_pkg::t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tod_pkg::REG_RAW_MODE:       r_cfg.raw_mode            <= i_cfg_data[0];
                tod_pkg::REG_EXPAND_TABS:    r_cfg.expand_tabs         <= i_cfg_data[0];
                tod_pkg::REG_UPPER_CASE:     r_cfg.upper_case_only     <= i_cfg_data[0];
                tod_pkg::REG_MAP_CRLF:       r_cfg.map_newline_to_crlf <= i_cfg_data[0];
                tod_pkg::REG_NEWLINE_DELAY:  r_cfg.newline_delay_kind  <= i_cfg_data;
                tod_pkg::REG_TAB_DELAY:      r_cfg.tab_delay_kind      <= i_cfg_data;
                tod_pkg::REG_RETURN_DELAY:   r_cfg.return_delay_kind   <= i_cfg_data;
                tod_pkg::REG_VERTICAL_DELAY: r_cfg.vertical_delay      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tod_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tod_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_char   (i_in.in_char),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last_of_run),
        .i_out_ready (o_out.ready)
    );

    // a pending byte that is not the last one means the character is still in work
    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_of_run) |-> !i_in.ready)
        else $error("input ready while a character is still being expanded");

    // a delay byte never carries zero ticks
    a_no_zero_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_byte[7]) |-> (o_out.out_byte[6:0] != 7'd0))
        else $error("zero-tick delay byte emitted");

    // an accepted character always leaves the idle state for the decode state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after a transaction");

endmodule

### dv/tod_test_pkg.sv
// character and register codes shared by the terminal output discipline testbench
`timescale 1ns / 100ps
package tod_test_pkg;

    localparam logic [6:0] CH_NUL     = 7'h00;
    localparam logic [6:0] CH_DEL     = 7'h7F;
    localparam logic [6:0] CH_BANG    = 7'h21;
    localparam logic [6:0] CH_QUOTE   = 7'h27;
    localparam logic [6:0] CH_LPAREN  = 7'h28;
    localparam logic [6:0] CH_RPAREN  = 7'h29;
    localparam logic [6:0] CH_CARET   = 7'h5E;
    localparam logic [6:0] CH_GRAVE   = 7'h60;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_Z = 7'h7A;
    localparam logic [6:0] CH_LBRACE  = 7'h7B;
    localparam logic [6:0] CH_VBAR    = 7'h7C;
    localparam logic [6:0] CH_RBRACE  = 7'h7D;

    // distance between lower and upper case letters
    localparam logic [6:0] CASE_GAP = 7'h20;

    // delay kind that selects no delay, like zero
    localparam logic [1:0] DLY_KIND_SPARE = 2'd3;

    // first register index that the block ignores
    localparam logic [tod_pkg::CfgIdxW-1:0] REG_UNUSED_BASE = 4'd8;

    // most queue bytes one character can produce
    localparam int MAX_RUN = 8;

endpackage

### dv/tod_output_checker.sv
// checker: predicts the queue bytes of each accepted character and compares them
`timescale 1ns / 100ps
module tod_output_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tod_in_if                               i_in,
    tod_out_if                              i_out,
    input  logic                            i_cfg_we,
    input  logic [tod_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [tod_pkg::CfgDataW-1:0]    i_cfg_data,
    output int                              o_fail_count,
    output int                              o_outstanding
);

    localparam int ReportLimit = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_queue_byte;

    tod_pkg::t_cfg cfg_q;
    logic [7:0]    head_col;
    t_queue_byte   expected_bytes [$];
    t_queue_byte   oldest;
    logic [7:0]    run_buf [tod_test_pkg::MAX_RUN];
    int            run_len;
    int            fail_total;

    function automatic void run_push(input logic [7:0] b);
        if (run_len < tod_test_pkg::MAX_RUN) begin
            run_buf[run_len] = b;
            run_len++;
        end
    endfunction

    // one character into the run, then its delay byte, and move the print head
    function automatic void print_char(input logic [6:0] c);
        logic [7:0]  col;
        int unsigned ticks;
        col = head_col;
        ticks = 0;
        run_push({1'b0, c});
        if (c >= tod_pkg::CH_SPACE && c <= tod_pkg::CH_TILDE) begin
            head_col = col + 8'd1;
        end else if (c == tod_pkg::CH_BS) begin
            if (col != 8'd0) head_col = col - 8'd1;
        end else if (c == tod_pkg::CH_LF) begin
            if (cfg_q.newline_delay_kind == tod_pkg::DLY_KIND_ONE) begin
                if (col != 8'd0) begin
                    ticks = (32'(col) >> 4) + 3;
                    if (ticks < 6) ticks = 6;
                end
            end else if (cfg_q.newline_delay_kind == tod_pkg::DLY_KIND_TWO) begin
                ticks = 6;
            end
            head_col = 8'd0;
        end else if (c == tod_pkg::CH_TAB) begin
            if (cfg_q.tab_delay_kind == tod_pkg::DLY_KIND_ONE) begin
                ticks = 9 - 32'(col & 8'd7);
                if (ticks < 5) ticks = 0;
            end
            head_col = (col | 8'd7) + 8'd1;
        end else if (c == tod_pkg::CH_VT || c == tod_pkg::CH_FF) begin
            if (cfg_q.vertical_delay) ticks = 127;
        end else if (c == tod_pkg::CH_CR) begin
            if (cfg_q.return_delay_kind == tod_pkg::DLY_KIND_ONE) ticks = 5;
            else if (cfg_q.return_delay_kind == tod_pkg::DLY_KIND_TWO) ticks = 10;
            head_col = 8'd0;
        end
        if (ticks != 0) run_push({1'b1, 7'(ticks)});
    endfunction

    function automatic void expand_char(input logic [6:0] c_in);
        logic [6:0] c;
        logic [6:0] sub;
        logic       has_sub;
        c = c_in;
        sub = c_in;
        run_len = 0;
        if (!(c == tod_pkg::CH_EOT && !cfg_q.raw_mode)) begin
            if (c == tod_pkg::CH_TAB && cfg_q.expand_tabs) begin
                do
                    print_char(tod_pkg::CH_SPACE);
                while (head_col[2:0] != 3'd0 && run_len < tod_test_pkg::MAX_RUN);
            end else begin
                if (cfg_q.upper_case_only) begin
                    has_sub = 1'b1;
                    case (c)
                        tod_test_pkg::CH_LBRACE: sub = tod_test_pkg::CH_LPAREN;
                        tod_test_pkg::CH_RBRACE: sub = tod_test_pkg::CH_RPAREN;
                        tod_test_pkg::CH_VBAR:   sub = tod_test_pkg::CH_BANG;
                        tod_pkg::CH_TILDE:       sub = tod_test_pkg::CH_CARET;
                        tod_test_pkg::CH_GRAVE:  sub = tod_test_pkg::CH_QUOTE;
                        default:                 has_sub = 1'b0;
                    endcase
                    if (has_sub) begin
                        print_char(tod_pkg::CH_BSL);
                        c = sub;
                    end
                    if (c >= tod_test_pkg::CH_LOWER_A && c <= tod_test_pkg::CH_LOWER_Z)
                        c = c - tod_test_pkg::CASE_GAP;
                end
                if (c == tod_pkg::CH_LF && cfg_q.map_newline_to_crlf)
                    print_char(tod_pkg::CH_CR);
                print_char(c);
            end
        end
        for (int k = 0; k < run_len; k++) begin
            expected_bytes.push_back('{out_byte: run_buf[k], last_of_run: (k == run_len - 1)});
        end
    endfunction

    function automatic void flag_failure(input string msg);
        if (fail_total < ReportLimit) $display("mismatch at %0t: %s", $realtime, msg);
        fail_total++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q = '0;
            head_col = 8'd0;
            expected_bytes.delete();
            fail_total = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tod_pkg::REG_RAW_MODE:       cfg_q.raw_mode = i_cfg_data[0];
                    tod_pkg::REG_EXPAND_TABS:    cfg_q.expand_tabs = i_cfg_data[0];
                    tod_pkg::REG_UPPER_CASE:     cfg_q.upper_case_only = i_cfg_data[0];
                    tod_pkg::REG_MAP_CRLF:       cfg_q.map_newline_to_crlf = i_cfg_data[0];
                    tod_pkg::REG_NEWLINE_DELAY:  cfg_q.newline_delay_kind = i_cfg_data;
                    tod_pkg::REG_TAB_DELAY:      cfg_q.tab_delay_kind = i_cfg_data;
                    tod_pkg::REG_RETURN_DELAY:   cfg_q.return_delay_kind = i_cfg_data;
                    tod_pkg::REG_VERTICAL_DELAY: cfg_q.vertical_delay = i_cfg_data[0];
                    default: ;
                endcase
            end
            // compare before predicting so a stray byte is never matched to a new run
            if (i_out.valid && i_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    flag_failure($sformatf("unexpected byte %02h (last %0b)",
                                           i_out.out_byte, i_out.last_of_run));
                end else begin
                    oldest = expected_bytes.pop_front();
                    if (i_out.out_byte !== oldest.out_byte)
                        flag_failure($sformatf("out_byte expected %02h, got %02h",
                                               oldest.out_byte, i_out.out_byte));
                    if (i_out.last_of_run !== oldest.last_of_run)
                        flag_failure($sformatf("last_of_run expected %0b, got %0b (byte %02h)",
                                               oldest.last_of_run, i_out.last_of_run,
                                               oldest.out_byte));
                end
            end
            if (i_in.valid && i_in.ready) expand_char(i_in.in_char);
        end
        o_fail_count  <= fail_total;
        o_outstanding <= expected_bytes.size();
    end

endmodule

### dv/terminal_output_discipline_test.sv
// top of the terminal output discipline testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module terminal_output_discipline_test;

    localparam int CfgBits     = $bits(tod_pkg::t_cfg);
    localparam int StallLimit  = 4000;
    localparam int DrainCycles = 16;
    localparam int RandPhases  = 7;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CADENCE, RX_TRICKLE} t_rx_mode;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [tod_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [tod_pkg::CfgDataW-1:0] i_cfg_data;
    logic                         rx_ready = 1'b0;
    int                           fail_count;
    int                           outstanding;

    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int unsigned rx_tick = 0;
    int          dead_cycles = 0;

    tod_in_if  in_ch ();
    tod_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    always #4 i_clk = ~i_clk;

    terminal_output_discipline dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tod_output_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // receiver stalls: a randomly picked pattern, held for a random span before the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            rx_left = 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(3, 0));
                rx_left = $urandom_range(200, 24);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:    rx_ready <= 1'b1;
                RX_COIN:    rx_ready <= 1'($urandom_range(1, 0));
                RX_CADENCE: rx_ready <= (rx_tick % 4) != 0;
                RX_TRICKLE: rx_ready <= ($urandom_range(5, 0) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            dead_cycles = 0;
        else
            dead_cycles++;
        if (dead_cycles >= StallLimit) begin
            $display("watchdog: no transaction for %0d cycles", StallLimit);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_char(input logic [6:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(10, 1);
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.in_char <= ch;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tod_pkg::CfgIdxW-1:0] idx,
                             input logic [tod_pkg::CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // unused upper bits of the one-bit registers get junk, they must be ignored
    task automatic program_regs(input tod_pkg::t_cfg c);
        write_reg(tod_pkg::REG_RAW_MODE, {1'($urandom_range(1, 0)), c.raw_mode});
        write_reg(tod_pkg::REG_EXPAND_TABS, {1'($urandom_range(1, 0)), c.expand_tabs});
        write_reg(tod_pkg::REG_UPPER_CASE, {1'($urandom_range(1, 0)), c.upper_case_only});
        write_reg(tod_pkg::REG_MAP_CRLF, {1'($urandom_range(1, 0)), c.map_newline_to_crlf});
        write_reg(tod_pkg::REG_NEWLINE_DELAY, c.newline_delay_kind);
        write_reg(tod_pkg::REG_TAB_DELAY, c.tab_delay_kind);
        write_reg(tod_pkg::REG_RETURN_DELAY, c.return_delay_kind);
        write_reg(tod_pkg::REG_VERTICAL_DELAY, {1'($urandom_range(1, 0)), c.vertical_delay});
        if ($urandom_range(1, 0) == 1)
            write_reg(tod_test_pkg::REG_UNUSED_BASE + 4'($urandom_range(7, 0)),
                      2'($urandom_range(3, 0)));
        i_cfg_we <= 1'b0;
    endtask

    // a dropped character leaves nothing to wait for, so the drain also covers it
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic logic [6:0] pick_char(input bit tab_heavy);
        int unsigned roll;
        logic [6:0]  ch;
        roll = $urandom_range(99, 0);
        if (tab_heavy) begin
            // long lines of tabs drive the column past its wrap
            if (roll < 75) ch = tod_pkg::CH_TAB;
            else if (roll < 97) ch = 7'($urandom_range(126, 32));
            else ch = 7'($urandom_range(127, 0));
        end else if (roll < 35) begin
            ch = 7'($urandom_range(126, 32));
        end else if (roll < 50) begin
            ch = 7'($urandom_range(tod_test_pkg::CH_LOWER_Z, tod_test_pkg::CH_LOWER_A));
        end else if (roll < 58) begin
            case ($urandom_range(4, 0))
                0:       ch = tod_test_pkg::CH_LBRACE;
                1:       ch = tod_test_pkg::CH_RBRACE;
                2:       ch = tod_test_pkg::CH_VBAR;
                3:       ch = tod_pkg::CH_TILDE;
                default: ch = tod_test_pkg::CH_GRAVE;
            endcase
        end else if (roll < 66) begin
            ch = tod_pkg::CH_TAB;
        end else if (roll < 74) begin
            ch = tod_pkg::CH_LF;
        end else if (roll < 80) begin
            ch = tod_pkg::CH_CR;
        end else if (roll < 84) begin
            ch = tod_pkg::CH_BS;
        end else if (roll < 88) begin
            ch = ($urandom_range(1, 0) == 1) ? tod_pkg::CH_FF : tod_pkg::CH_VT;
        end else if (roll < 92) begin
            ch = tod_pkg::CH_EOT;
        end else begin
            ch = 7'($urandom_range(127, 0));
        end
        return ch;
    endfunction

    initial begin : stimulus
        logic [6:0]    chars [$];
        tod_pkg::t_cfg cfg;
        int            sent;
        int            quota;
        bit            tab_heavy;
        logic [6:0]    ch;

        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_char <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: eot dropped, no folding, no delays
        chars = '{tod_test_pkg::CH_NUL, tod_pkg::CH_EOT, tod_pkg::CH_BS,
                  tod_test_pkg::CH_LOWER_A, tod_test_pkg::CH_LBRACE, tod_pkg::CH_TAB,
                  tod_pkg::CH_BS, tod_test_pkg::CH_DEL, tod_pkg::CH_LF, tod_pkg::CH_CR,
                  tod_pkg::CH_VT};
        foreach (chars[k]) send_char(chars[k]);
        wait_idle();

        // everything but tab expansion on, kind one delays
        program_regs(tod_pkg::t_cfg'{raw_mode: 1'b1, expand_tabs: 1'b0,
                                     upper_case_only: 1'b1, map_newline_to_crlf: 1'b1,
                                     newline_delay_kind: tod_pkg::DLY_KIND_ONE,
                                     tab_delay_kind: tod_pkg::DLY_KIND_ONE,
                                     return_delay_kind: tod_pkg::DLY_KIND_ONE,
                                     vertical_delay: 1'b1});
        chars = '{tod_pkg::CH_EOT, tod_test_pkg::CH_LBRACE, tod_test_pkg::CH_RBRACE,
                  tod_test_pkg::CH_VBAR, tod_pkg::CH_TILDE, tod_test_pkg::CH_GRAVE,
                  tod_test_pkg::CH_LOWER_Z, tod_pkg::CH_TAB, tod_pkg::CH_LF,
                  tod_pkg::CH_FF, tod_pkg::CH_CR};
        foreach (chars[k]) send_char(chars[k]);
        wait_idle();

        // tab expansion, the other delay kinds
        program_regs(tod_pkg::t_cfg'{raw_mode: 1'b0, expand_tabs: 1'b1,
                                     upper_case_only: 1'b0, map_newline_to_crlf: 1'b0,
                                     newline_delay_kind: tod_pkg::DLY_KIND_TWO,
                                     tab_delay_kind: tod_test_pkg::DLY_KIND_SPARE,
                                     return_delay_kind: tod_pkg::DLY_KIND_TWO,
                                     vertical_delay: 1'b0});
        chars = '{tod_pkg::CH_TAB, tod_test_pkg::CH_LOWER_A, tod_pkg::CH_TAB, tod_pkg::CH_CR};
        foreach (chars[k]) send_char(chars[k]);
        wait_idle();

        for (int phase = 0; phase < RandPhases; phase++) begin
            cfg = tod_pkg::t_cfg'(CfgBits'($urandom));
            program_regs(cfg);
            no_gaps   = ($urandom_range(3, 0) == 0);
            tab_heavy = (phase % 3 == 1);
            quota     = tab_heavy ? 60 : 42;
            sent      = 0;
            while (sent < quota) begin
                ch = pick_char(tab_heavy);
                send_char(ch);
                if (!(ch == tod_pkg::CH_EOT && !cfg.raw_mode)) sent++;
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
